>>> hw/rtl/esdp_pkg.sv
// Shared constants and types of the elastic sequence distance core.
`default_nettype none
package esdp_pkg;

  localparam int FIELD_W    = 32;
  localparam int WEIGHT_W   = 17;
  localparam int LEN_W      = 9;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 5 * FIELD_W;
  localparam int OUT_DATA_W = 40;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT = 2'd0,
    REG_ROWS   = 2'd1,
    REG_COLS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } cell_pos_t;

endpackage
`default_nettype wire

>>> hw/rtl/elastic_sequence_distance_dp_core.sv
// Top level of the elastic sequence distance core.
`default_nettype none
// Time warp edit distance over a grid streamed in row-major order, one cell
// per transfer. The core takes one cell every clock while input is not held
// off: the only loop that must close between cells is the add-and-min from
// the left neighbor in the final stage, and the previous-row memory does one
// read and one write per cycle. The result of a run passes stages s1 to s4
// and then the result register. Input is held off only when a second result
// reaches the final stage while the previous one is still waiting on the
// output. Any register write restarts the run; write registers only while
// the core is idle. The row memory needs no clearing after reset.
module elastic_sequence_distance_dp_core
  import esdp_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cell_cost, row_diag_dist, row_time, col_diag_dist, col_time
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // distance, saturated, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CI_W = $clog2(MAX_COLS);

  logic [WEIGHT_W-1:0] weight;
  logic [LEN_W-1:0]    rows_used;
  logic [LEN_W-1:0]    cols_used;
  logic [WEIGHT_W-1:0] weight_eff;
  logic                restart;
  logic                stall;
  logic                advance;

  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_cost, s1_rdist, s1_cdist;
  logic [FIELD_W-1:0]    s1_rgap, s1_cgap;
  cell_pos_t             s1_pos;
  logic [CI_W-1:0]       s1_ci;

  logic                  s2_valid, s3_valid;
  logic [VALUE_BITS-1:0] s2_cost, s3_cost;
  cell_pos_t             s2_pos, s3_pos;
  logic [CI_W-1:0]       s2_ci, s3_ci;

  logic [VALUE_BITS-1:0] costr, costt;
  logic                  satr, satt;
  logic [FIELD_W-1:0]    out_distance;
  logic                  out_saturated;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_WEIGHT, REG_ROWS, REG_COLS: restart = cfg_we;
      default:                        restart = 1'b0;
    endcase
    weight_eff    = (weight > ONE_Q16) ? ONE_Q16 : weight;
    advance       = !stall;
    s_axis_tready = advance;
    m_axis_tdata  = {{(OUT_DATA_W - FIELD_W - 1){1'b0}}, out_saturated, out_distance};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= '0;
      rows_used <= LEN_W'(1);
      cols_used <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WEIGHT: weight    <= cfg_data;
        REG_ROWS:   rows_used <= cfg_data[LEN_W-1:0];
        REG_COLS:   cols_used <= cfg_data[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cost <= s1_cost;
      s2_pos  <= s1_pos;
      s2_ci   <= s1_ci;
      s3_cost <= s2_cost;
      s3_pos  <= s2_pos;
      s3_ci   <= s2_ci;
    end
  end

  esdp_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .advance   (advance),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .s1_valid  (s1_valid),
    .s1_cost   (s1_cost),
    .s1_rdist  (s1_rdist),
    .s1_cdist  (s1_cdist),
    .s1_rgap   (s1_rgap),
    .s1_cgap   (s1_cgap),
    .s1_pos    (s1_pos),
    .s1_ci     (s1_ci)
  );

  esdp_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step_row (
    .clk     (clk),
    .advance (advance),
    .weight  (weight_eff),
    .skip    (s1_pos.first_row),
    .dist_in (s1_rdist),
    .gap     (s1_rgap),
    .cost    (costr),
    .sat     (satr)
  );

  esdp_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step_col (
    .clk     (clk),
    .advance (advance),
    .weight  (weight_eff),
    .skip    (s1_pos.first_col),
    .dist_in (s1_cdist),
    .gap     (s1_cgap),
    .cost    (costt),
    .sat     (satt)
  );

  esdp_cell #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_COLS   (MAX_COLS)
  ) u_cell (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .in_valid      (s3_valid),
    .in_ci         (s3_ci),
    .in_cost       (s3_cost),
    .in_pos        (s3_pos),
    .costr         (costr),
    .costt         (costt),
    .step_sat      (satr | satt),
    .out_ready     (m_axis_tready),
    .stall         (stall),
    .out_valid     (m_axis_tvalid),
    .out_distance  (out_distance),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

>>> hw/rtl/esdp_front.sv
// Input stage: grid position tracking, input clamping and time gaps.
`default_nettype none
module esdp_front
  import esdp_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  restart,
  input  wire logic                  advance,
  input  wire logic                  in_valid,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic [LEN_W-1:0]      rows_used,
  input  wire logic [LEN_W-1:0]      cols_used,
  output logic                       s1_valid,
  output logic [VALUE_BITS-1:0]      s1_cost,
  output logic [VALUE_BITS-1:0]      s1_rdist,
  output logic [VALUE_BITS-1:0]      s1_cdist,
  output logic [FIELD_W-1:0]         s1_rgap,
  output logic [FIELD_W-1:0]         s1_cgap,
  output cell_pos_t                  s1_pos,
  output logic [$clog2(MAX_COLS)-1:0] s1_ci
);

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int WIDE_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  function automatic logic [VALUE_BITS-1:0] clampv(input logic [FIELD_W-1:0] x);
    logic [WIDE_W-1:0] xe;
    xe = WIDE_W'(x);
    if (xe > WIDE_W'(VMAX)) return VMAX;
    return VALUE_BITS'(xe);
  endfunction

  function automatic logic [FIELD_W-1:0] absdiff(input logic [FIELD_W-1:0] a,
                                                 input logic [FIELD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [ROW_W-1:0]   row_pos;
  logic [COL_W-1:0]   col_pos;
  logic [FIELD_W-1:0] last_row_time;
  logic [FIELD_W-1:0] last_col_time;
  logic [ROW_W-1:0]   nr;
  logic [COL_W-1:0]   nc;
  logic [31:0]        rows_ext;
  logic [31:0]        cols_ext;
  logic [FIELD_W-1:0] f_cost, f_rdist, f_rtime, f_cdist, f_ctime;
  cell_pos_t          pos;

  always_comb begin
    rows_ext = 32'(rows_used);
    cols_ext = 32'(cols_used);
    if (rows_ext == 32'd0)                nr = ROW_W'(1);
    else if (rows_ext > 32'(MAX_ROWS))    nr = ROW_W'(MAX_ROWS);
    else                                  nr = ROW_W'(rows_ext);
    if (cols_ext == 32'd0)                nc = COL_W'(1);
    else if (cols_ext > 32'(MAX_COLS))    nc = COL_W'(MAX_COLS);
    else                                  nc = COL_W'(cols_ext);

    f_cost  = in_data[FIELD_W-1:0];
    f_rdist = in_data[2*FIELD_W-1:FIELD_W];
    f_rtime = in_data[3*FIELD_W-1:2*FIELD_W];
    f_cdist = in_data[4*FIELD_W-1:3*FIELD_W];
    f_ctime = in_data[5*FIELD_W-1:4*FIELD_W];

    pos.first_row = (row_pos == ROW_W'(1));
    pos.first_col = (col_pos == COL_W'(1));
    pos.last_col  = (col_pos >= nc);
    pos.last_row  = (row_pos >= nr);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid      <= 1'b0;
      row_pos       <= ROW_W'(1);
      col_pos       <= COL_W'(1);
      last_row_time <= '0;
      last_col_time <= '0;
    end else if (advance) begin
      s1_valid <= in_valid;
      if (in_valid) begin
        if (pos.last_col && pos.last_row) begin
          row_pos       <= ROW_W'(1);
          col_pos       <= COL_W'(1);
          last_row_time <= '0;
          last_col_time <= '0;
        end else if (pos.last_col) begin
          row_pos       <= row_pos + ROW_W'(1);
          col_pos       <= COL_W'(1);
          last_row_time <= f_rtime;
          last_col_time <= f_ctime;
        end else begin
          col_pos       <= col_pos + COL_W'(1);
          last_col_time <= f_ctime;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cost  <= clampv(f_cost);
      s1_rdist <= clampv(f_rdist);
      s1_cdist <= clampv(f_cdist);
      s1_rgap  <= absdiff(f_rtime, last_row_time);
      s1_cgap  <= absdiff(f_ctime, last_col_time);
      s1_pos   <= pos;
      s1_ci    <= CI_W'(col_pos - COL_W'(1));
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/esdp_step.sv
// Two-stage step cost unit: weighted distance plus weighted time gap, rounded.
`default_nettype none
module esdp_step
  import esdp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  advance,
  input  wire logic [WEIGHT_W-1:0]   weight,
  input  wire logic                  skip,
  input  wire logic [VALUE_BITS-1:0] dist_in,
  input  wire logic [FIELD_W-1:0]    gap,
  output logic [VALUE_BITS-1:0]      cost,
  output logic                       sat
);

  localparam int PD_W  = VALUE_BITS + WEIGHT_W;
  localparam int PG_W  = FIELD_W + WEIGHT_W;
  localparam int ACC_W = ((PD_W > PG_W) ? PD_W : PG_W) + 1;
  localparam int R_W   = ACC_W - FRAC_W;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  logic [PD_W-1:0]     prod_d;
  logic [PG_W-1:0]     prod_g;
  logic                skip_a;
  logic [WEIGHT_W-1:0] one_minus_w;
  logic [ACC_W-1:0]    acc;
  logic [R_W-1:0]      r;

  always_comb begin
    one_minus_w = ONE_Q16 - weight;
    acc = ACC_W'(prod_d) + ACC_W'(prod_g) + ROUND;
    r   = acc[ACC_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_d <= PD_W'(one_minus_w) * PD_W'(dist_in);
      prod_g <= PG_W'(weight) * PG_W'(gap);
      skip_a <= skip;
      if (skip_a) begin
        cost <= '0;
        sat  <= 1'b0;
      end else if (r >= R_W'(VMAX)) begin
        cost <= VMAX;
        sat  <= 1'b1;
      end else begin
        cost <= VALUE_BITS'(r);
        sat  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/esdp_cell.sv
// Recurrence stage: previous-row memory, add-and-min update, result register.
`default_nettype none
module esdp_cell
  import esdp_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_COLS   = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        restart,
  input  wire logic                        in_valid,
  input  wire logic [$clog2(MAX_COLS)-1:0] in_ci,
  input  wire logic [VALUE_BITS-1:0]       in_cost,
  input  wire cell_pos_t                   in_pos,
  input  wire logic [VALUE_BITS-1:0]       costr,
  input  wire logic [VALUE_BITS-1:0]       costt,
  input  wire logic                        step_sat,
  input  wire logic                        out_ready,
  output logic                             stall,
  output logic                             out_valid,
  output logic [FIELD_W-1:0]               out_distance,
  output logic                             out_saturated
);

  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int WIDE_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  // Returns {overflow, sum}; an infinite operand gives infinity with no overflow.
  function automatic logic [VALUE_BITS:0] sat_add(input logic [VALUE_BITS-1:0] a,
                                                  input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == VMAX || b == VMAX) return {1'b0, VMAX};
    if (s >= {1'b0, VMAX})      return {1'b1, VMAX};
    return s;
  endfunction

  // entry: {match cost, dp value}
  logic [2*VALUE_BITS-1:0] row_mem [MAX_COLS];
  logic [2*VALUE_BITS-1:0] rd;

  logic                  s4_valid;
  logic [CI_W-1:0]       s4_ci;
  logic [VALUE_BITS-1:0] s4_cost;
  cell_pos_t             s4_pos;
  logic [VALUE_BITS-1:0] s4_costr;
  logic [VALUE_BITS-1:0] s4_costt;
  logic                  s4_step_sat;

  logic [VALUE_BITS-1:0] left_value;
  logic [VALUE_BITS-1:0] diag_value;
  logic [VALUE_BITS-1:0] diag_cost;
  logic [VALUE_BITS-1:0] last_v;
  logic                  sat_flag;

  logic                  advance;
  logic                  is_result;
  logic [VALUE_BITS-1:0] up;
  logic [VALUE_BITS-1:0] old_cost;
  logic [VALUE_BITS:0]   del_r, ins_r, m1_r, m2_r;
  logic [VALUE_BITS-1:0] v;
  logic                  cell_sat;
  logic [WIDE_W-1:0]     v_wide;
  logic [FIELD_W-1:0]    dist_out;

  always_comb begin
    is_result = s4_pos.last_col && s4_pos.last_row;
    stall     = s4_valid && is_result && out_valid && !out_ready;
    advance   = !stall;

    // single-column grid: the entry above is the cell just finished
    if (s4_pos.first_row)                         up = VMAX;
    else if (s4_pos.first_col && s4_pos.last_col) up = last_v;
    else                                          up = rd[VALUE_BITS-1:0];
    old_cost = rd[2*VALUE_BITS-1:VALUE_BITS];

    del_r = sat_add(up, s4_costr);
    ins_r = sat_add(left_value, s4_costt);
    m1_r  = sat_add(diag_value, s4_cost);
    m2_r  = sat_add(m1_r[VALUE_BITS-1:0],
                    (s4_pos.first_row || s4_pos.first_col) ? '0 : diag_cost);

    v = (del_r[VALUE_BITS-1:0] < ins_r[VALUE_BITS-1:0]) ?
        del_r[VALUE_BITS-1:0] : ins_r[VALUE_BITS-1:0];
    if (m2_r[VALUE_BITS-1:0] < v) v = m2_r[VALUE_BITS-1:0];

    cell_sat = del_r[VALUE_BITS] | ins_r[VALUE_BITS] | m1_r[VALUE_BITS] |
               m2_r[VALUE_BITS] | s4_step_sat;

    v_wide   = WIDE_W'(v);
    dist_out = (v_wide > WIDE_W'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : FIELD_W'(v_wide);
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) rd <= row_mem[in_ci];
    if (advance && s4_valid) row_mem[s4_ci] <= {s4_cost, v};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_ci       <= in_ci;
      s4_cost     <= in_cost;
      s4_pos      <= in_pos;
      s4_costr    <= costr;
      s4_costt    <= costt;
      s4_step_sat <= step_sat;
      if (s4_valid) last_v <= v;
    end
    if (advance && s4_valid && is_result) begin
      out_distance  <= dist_out;
      out_saturated <= sat_flag | cell_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid   <= 1'b0;
      out_valid  <= 1'b0;
      left_value <= VMAX;
      diag_value <= '0;
      diag_cost  <= '0;
      sat_flag   <= 1'b0;
    end else if (restart) begin
      s4_valid   <= 1'b0;
      left_value <= VMAX;
      diag_value <= '0;
      diag_cost  <= '0;
      sat_flag   <= 1'b0;
    end else begin
      if (advance && s4_valid && is_result) out_valid <= 1'b1;
      else if (out_ready)                   out_valid <= 1'b0;
      if (advance) begin
        s4_valid <= in_valid;
        if (s4_valid) begin
          if (is_result) begin
            left_value <= VMAX;
            diag_value <= '0;
            diag_cost  <= '0;
            sat_flag   <= 1'b0;
          end else if (s4_pos.last_col) begin
            left_value <= VMAX;
            diag_value <= VMAX;
            diag_cost  <= '0;
            sat_flag   <= sat_flag | cell_sat;
          end else begin
            left_value <= v;
            diag_value <= up;
            diag_cost  <= old_cost;
            sat_flag   <= sat_flag | cell_sat;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire
